### rtl/pmid_pkg.sv
package pmid_pkg;

    // fixed field widths
    localparam int IN_W   = 21;
    localparam int OUT_W  = 24;
    localparam int REG_W  = 63;
    localparam int DATA_W = 64;
    localparam int ADDR_W = 5;

    // default coordinate width
    localparam int COORD_WIDTH = 21;

    // number of periodic images and leaves of the min tree
    localparam int NIMG    = 27;
    localparam int NLEAF   = 32;
    localparam int NLEVELS = 5;

    // register map indexes
    typedef enum logic [1:0] {
        REG_LAT_A = 2'd0,
        REG_LAT_B = 2'd1,
        REG_LAT_C = 2'd2,
        REG_CAP   = 2'd3
    } reg_idx_t;

endpackage

### rtl/pmid_in_if.sv
interface pmid_in_if;
    logic                              valid;
    logic                              ready;
    logic signed [pmid_pkg::IN_W-1:0]  first_x;
    logic signed [pmid_pkg::IN_W-1:0]  first_y;
    logic signed [pmid_pkg::IN_W-1:0]  first_z;
    logic signed [pmid_pkg::IN_W-1:0]  second_x;
    logic signed [pmid_pkg::IN_W-1:0]  second_y;
    logic signed [pmid_pkg::IN_W-1:0]  second_z;

    modport source (
        output valid, first_x, first_y, first_z, second_x, second_y, second_z,
        input  ready
    );
    modport sink (
        input  valid, first_x, first_y, first_z, second_x, second_y, second_z,
        output ready
    );
endinterface

### rtl/pmid_out_if.sv
interface pmid_out_if;
    logic                        valid;
    logic                        ready;
    logic [pmid_pkg::OUT_W-1:0]  min_distance;

    modport source (
        output valid, min_distance,
        input  ready
    );
    modport sink (
        input  valid, min_distance,
        output ready
    );
endinterface

### rtl/periodic_min_image_distance_core.sv
// Periodic minimum-image distance: each input transaction carries two 3D
// positions, and one output transaction returns the smallest length of
// their difference over the 27 lattice images, capped and rounded down.
// The block is a fixed pipeline that takes one transaction per clock while the
// output is not stalled, and returns each result through these registered steps:
// difference, image sums, squares, three-term sum, a five-level registered
// min tree and a square root that resolves one result bit per stage.
// A stall at the output freezes the whole pipeline. Lattice registers sit
// at byte addresses 0, 8 and 16, cap_mode at 24; configure while idle and
// allow three cycles for the cap value to settle after a write.
module periodic_min_image_distance_core #(
    parameter int COORD_WIDTH = pmid_pkg::COORD_WIDTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pmid_pkg::ADDR_W-1:0]   paddr,
    input  logic [pmid_pkg::DATA_W-1:0]   pwdata,
    output logic [pmid_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    pmid_in_if.sink                       in_ch,
    pmid_out_if.source                    out_ch
);

    localparam int W     = COORD_WIDTH;
    localparam int D_W   = W + 1;
    localparam int IMG_W = W + 3;
    localparam int SQ_W  = 2 * IMG_W;
    localparam int RT_W  = IMG_W;
    localparam int RM_W  = RT_W + 2;
    localparam int NNODE = pmid_pkg::NLEAF - 1;

    // configuration registers
    logic [pmid_pkg::REG_W-1:0] lat_reg [3];
    logic                       cap_mode_reg;
    pmid_pkg::reg_idx_t         idx;

    assign idx    = pmid_pkg::reg_idx_t'(paddr[pmid_pkg::ADDR_W-1:3]);
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lat_reg[0]   <= '0;
            lat_reg[1]   <= '0;
            lat_reg[2]   <= '0;
            cap_mode_reg <= 1'b0;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (idx)
                pmid_pkg::REG_LAT_A: lat_reg[0] <= pwdata[pmid_pkg::REG_W-1:0];
                pmid_pkg::REG_LAT_B: lat_reg[1] <= pwdata[pmid_pkg::REG_W-1:0];
                pmid_pkg::REG_LAT_C: lat_reg[2] <= pwdata[pmid_pkg::REG_W-1:0];
                pmid_pkg::REG_CAP:   cap_mode_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    // register read back
    always_comb
    begin
        unique case (idx)
            pmid_pkg::REG_LAT_A: prdata = {1'b0, lat_reg[0]};
            pmid_pkg::REG_LAT_B: prdata = {1'b0, lat_reg[1]};
            pmid_pkg::REG_LAT_C: prdata = {1'b0, lat_reg[2]};
            pmid_pkg::REG_CAP:   prdata = {{(pmid_pkg::DATA_W-1){1'b0}}, cap_mode_reg};
            default:             prdata = '0;
        endcase
    end

    // lattice components, lc[vector][axis]
    logic signed [W-1:0] lc [3][3];
    always_comb
    begin
        for (int v = 0; v < 3; v++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                lc[v][i] = lat_reg[v][i*W +: W];
            end
        end
    end

    // cap value, pipelined from the configuration
    logic signed [IMG_W-1:0] cs_reg [3];
    logic [SQ_W-1:0]         csq_reg [3];
    logic [SQ_W-1:0]         cap_reg;
    logic signed [SQ_W-1:0]  cs_ext [3];
    logic [SQ_W-1:0]         cap_sum;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            cs_ext[i] = SQ_W'(cs_reg[i]);
        end
        cap_sum = csq_reg[0] + csq_reg[1] + csq_reg[2];
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            cs_reg[i]  <= IMG_W'(lc[0][i]) + IMG_W'(lc[1][i]) + IMG_W'(lc[2][i]);
            csq_reg[i] <= SQ_W'($unsigned(cs_ext[i] * cs_ext[i]));
        end
        cap_reg <= cap_mode_reg ? {SQ_W{1'b1}} : {cap_sum[SQ_W-3:0], 2'b00};
    end

    // pipeline advance: a stalled output holds every stage
    logic en;
    logic out_v;
    assign en          = !out_v || out_ch.ready;
    assign in_ch.ready = en;

    // stage 1: difference vector
    logic                  v1_reg;
    logic signed [D_W-1:0] d_reg [3];
    logic signed [W-1:0]   p1 [3];
    logic signed [W-1:0]   p2 [3];

    assign p1[0] = in_ch.first_x[W-1:0];
    assign p1[1] = in_ch.first_y[W-1:0];
    assign p1[2] = in_ch.first_z[W-1:0];
    assign p2[0] = in_ch.second_x[W-1:0];
    assign p2[1] = in_ch.second_y[W-1:0];
    assign p2[2] = in_ch.second_z[W-1:0];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                d_reg[i] <= D_W'(p1[i]) - D_W'(p2[i]);
            end
        end
    end

    // stage 2 and 3: image vectors, then their squared components
    logic                    v2_reg;
    logic                    v3_reg;
    logic signed [IMG_W-1:0] img_reg [pmid_pkg::NIMG][3];
    logic [SQ_W-1:0]         sq_reg  [pmid_pkg::NIMG][3];

    for (genvar j = 0; j < pmid_pkg::NIMG; j++)
    begin : g_img
        localparam int K = j / 9 - 1;
        localparam int L = (j / 3) % 3 - 1;
        localparam int M = j % 3 - 1;
        for (genvar i = 0; i < 3; i++)
        begin : g_ax
            logic signed [IMG_W-1:0] ta;
            logic signed [IMG_W-1:0] tb;
            logic signed [IMG_W-1:0] tc;
            logic signed [SQ_W-1:0]  ie;
            assign ta = (K == 1) ? IMG_W'(lc[0][i]) : (K == -1) ? -IMG_W'(lc[0][i]) : '0;
            assign tb = (L == 1) ? IMG_W'(lc[1][i]) : (L == -1) ? -IMG_W'(lc[1][i]) : '0;
            assign tc = (M == 1) ? IMG_W'(lc[2][i]) : (M == -1) ? -IMG_W'(lc[2][i]) : '0;
            assign ie = SQ_W'(img_reg[j][i]);
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    img_reg[j][i] <= IMG_W'(d_reg[i]) + ta + tb + tc;
                    sq_reg[j][i]  <= SQ_W'($unsigned(ie * ie));
                end
            end
        end
    end

    // stage 4 and on: leaves and registered min tree, heap order
    logic [SQ_W-1:0] tr_reg [NNODE + pmid_pkg::NLEAF];
    logic            tv_reg [pmid_pkg::NLEVELS + 1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < pmid_pkg::NLEAF; j++)
            begin
                if (j < pmid_pkg::NIMG)
                begin
                    tr_reg[NNODE + j] <= sq_reg[j][0] + sq_reg[j][1] + sq_reg[j][2];
                end
                else if (j == pmid_pkg::NIMG)
                begin
                    tr_reg[NNODE + j] <= cap_reg;
                end
                else
                begin
                    tr_reg[NNODE + j] <= {SQ_W{1'b1}};
                end
            end
            for (int n = 0; n < NNODE; n++)
            begin
                tr_reg[n] <= (tr_reg[2*n+2] < tr_reg[2*n+1]) ? tr_reg[2*n+2]
                                                             : tr_reg[2*n+1];
            end
        end
    end

    // square root, one result bit per stage
    logic             sv_reg   [RT_W];
    logic [RM_W-1:0]  rem_reg  [RT_W];
    logic [RT_W-1:0]  root_reg [RT_W];
    logic [SQ_W-1:0]  val_reg  [RT_W];
    logic [RM_W-1:0]  rem_next [RT_W];
    logic [RT_W-1:0]  root_next[RT_W];
    logic [SQ_W-1:0]  val_next [RT_W];

    always_comb
    begin
        logic [RM_W-1:0] r_in;
        logic [RT_W-1:0] q_in;
        logic [SQ_W-1:0] x_in;
        logic [RM_W-1:0] r_sh;
        logic [RM_W-1:0] trial;
        for (int s = 0; s < RT_W; s++)
        begin
            if (s == 0)
            begin
                r_in = '0;
                q_in = '0;
                x_in = tr_reg[0];
            end
            else
            begin
                r_in = rem_reg[s-1];
                q_in = root_reg[s-1];
                x_in = val_reg[s-1];
            end
            r_sh  = {r_in[RM_W-3:0], x_in[SQ_W-1:SQ_W-2]};
            trial = {q_in, 2'b01};
            val_next[s] = {x_in[SQ_W-3:0], 2'b00};
            if (r_sh >= trial)
            begin
                rem_next[s]  = r_sh - trial;
                root_next[s] = {q_in[RT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[s]  = r_sh;
                root_next[s] = {q_in[RT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < RT_W; s++)
            begin
                rem_reg[s]  <= rem_next[s];
                root_reg[s] <= root_next[s];
                val_reg[s]  <= val_next[s];
            end
        end
    end

    // valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            for (int t = 0; t <= pmid_pkg::NLEVELS; t++)
            begin
                tv_reg[t] <= 1'b0;
            end
            for (int s = 0; s < RT_W; s++)
            begin
                sv_reg[s] <= 1'b0;
            end
        end
        else if (en)
        begin
            v1_reg    <= in_ch.valid;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            tv_reg[0] <= v3_reg;
            for (int t = 1; t <= pmid_pkg::NLEVELS; t++)
            begin
                tv_reg[t] <= tv_reg[t-1];
            end
            sv_reg[0] <= tv_reg[pmid_pkg::NLEVELS];
            for (int s = 1; s < RT_W; s++)
            begin
                sv_reg[s] <= sv_reg[s-1];
            end
        end
    end

    // output transaction
    assign out_v               = sv_reg[RT_W-1];
    assign out_ch.valid        = out_v;
    assign out_ch.min_distance = pmid_pkg::OUT_W'(root_reg[RT_W-1]);

endmodule
